// File: design/lbp_code_stream_macros.svh
// Assertion macros shared by the local binary pattern block.
// Expects clk and arst_n in the scope of each use.
`ifndef LBP_CODE_STREAM_MACROS_SVH
`define LBP_CODE_STREAM_MACROS_SVH

// same-cycle implication, off during reset
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lbp_pkg.sv
// Shared types and constants for the local binary pattern stream block.
// No dependencies.
package lbp_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int PIX_W         = 8;
	localparam int FW_W          = 11;
	localparam int FH_W          = 12;
	localparam int ROW_W         = 12;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 12;
	localparam int MIN_DIM       = 3;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 12'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t pixel;
		logic   frame_start;
	} pix_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] lbp_code;
		logic             row_last;
		logic             frame_last;
	} code_word_t;

	// one line store entry: the same column of the two previous rows
	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_pair_t;

endpackage

// File: design/lbp_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
// Payload types come from lbp_pkg.
interface lbp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/lbp_line_buf.sv
// Two-row line store: one entry per column, read registered, with write-to-read
// forwarding for a read of the column written on the same edge. Uses lbp_pkg.
module lbp_line_buf #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [COL_W-1:0]    rd_addr,
	input  logic                wr_en,
	input  logic [COL_W-1:0]    wr_addr,
	input  lbp_pkg::line_pair_t wr_data,
	output lbp_pkg::line_pair_t rd_data
);

	lbp_pkg::line_pair_t mem [MAX_WIDTH];
	lbp_pkg::line_pair_t rd_q;
	lbp_pkg::line_pair_t fwd_q;
	logic                fwd_sel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			fwd_sel_q <= wr_en && (wr_addr == rd_addr);
			fwd_q     <= wr_data;
		end
	end

	assign rd_data = fwd_sel_q ? fwd_q : rd_q;

endmodule

// File: design/lbp_code_stream.sv
// 3x3 local binary pattern codes over a raster pixel stream.
// Throughput: one pixel word per clock when the output is not stalled, set by one line
// store read and one write per clock. Codes go through stage 1 and the output register.
// Reset clears position, window and handshake state and sets a 640x480 frame;
// the line store is not cleared and holds garbage until rows are written.
`include "lbp_code_stream_macros.svh"

module lbp_code_stream #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	lbp_stream_if.sink                      pix,
	lbp_stream_if.source                    code
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int FW_W  = lbp_pkg::FW_W;
	localparam int FH_W  = lbp_pkg::FH_W;
	localparam int ROW_W = lbp_pkg::ROW_W;
	localparam int CMP_W = (WID_W > FW_W) ? WID_W : FW_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lbp_pkg::FW_RESET;
			frame_height_q <= lbp_pkg::FH_RESET;
		end else if (cfg_we) begin
			unique case (lbp_pkg::cfg_reg_t'(cfg_index))
				lbp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				lbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: width clamped to [3, MAX_WIDTH], height at least 3
	logic [CMP_W-1:0] fw_ext;
	logic [WID_W-1:0] w_eff;
	logic [FH_W-1:0]  h_eff;

	assign fw_ext = CMP_W'(frame_width_q);

	always_comb begin
		priority if (fw_ext < CMP_W'(lbp_pkg::MIN_DIM)) begin
			w_eff = WID_W'(lbp_pkg::MIN_DIM);
		end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(fw_ext);
		end
	end

	assign h_eff = (frame_height_q < FH_W'(lbp_pkg::MIN_DIM)) ?
		FH_W'(lbp_pkg::MIN_DIM) : frame_height_q;

	// ---------------------------------------------------------------
	// Handshake control
	// ---------------------------------------------------------------
	logic accept;
	logic s1_valid;
	logic s1_adv;
	logic out_valid_q;
	logic out_free;
	logic emit_s1;

	assign out_free  = !out_valid_q || code.ready;
	// a word that makes no code leaves stage 1 without needing the output slot
	assign s1_adv    = s1_valid && (!emit_s1 || out_free);
	assign pix.ready = !s1_valid || s1_adv;
	assign accept    = pix.valid && pix.ready;

	// ---------------------------------------------------------------
	// Raster position of the incoming word
	// ---------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WID_W-1:0] col_a;
	logic [ROW_W:0]   row_a;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic [WID_W-1:0] col_n;
	logic [ROW_W:0]   row_n;
	logic             emit_c;
	logic             row_last_c;
	logic             frame_last_c;

	always_comb begin
		// frame start clears position; a stale column (after a width change)
		// rolls to the next row, a stale row to row 0
		col_a = pix.data.frame_start ? '0 : WID_W'(col_q);
		row_a = pix.data.frame_start ? '0 : {1'b0, row_q};
		if (col_a >= w_eff) begin
			col_a = '0;
			row_a = row_a + 1'b1;
		end
		if (row_a >= {1'b0, h_eff}) begin
			row_a = '0;
		end
		col_c = col_a[COL_W-1:0];
		row_c = row_a[ROW_W-1:0];

		emit_c       = (row_c >= ROW_W'(2)) && (col_a >= WID_W'(2));
		row_last_c   = (col_a == w_eff - 1'b1);
		frame_last_c = row_last_c && (row_c == h_eff - 1'b1);

		// position after this word, wrapping at end of row and frame
		col_n = col_a + 1'b1;
		row_n = {1'b0, row_c};
		if (col_n >= w_eff) begin
			col_n = '0;
			row_n = {1'b0, row_c} + 1'b1;
			if (row_n >= {1'b0, h_eff}) begin
				row_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n[COL_W-1:0];
			row_q <= row_n[ROW_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line store read lands, window shifts
	// ---------------------------------------------------------------
	lbp_pkg::pixel_t     px_s1;
	logic [COL_W-1:0]    col_s1;
	logic                row_last_s1;
	logic                frame_last_s1;
	lbp_pkg::line_pair_t lb_rd;
	lbp_pkg::line_pair_t lb_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1         <= pix.data.pixel;
			col_s1        <= col_c;
			emit_s1       <= emit_c;
			row_last_s1   <= row_last_c;
			frame_last_s1 <= frame_last_c;
		end
	end

	// the column moves up one row: newer becomes older, the new pixel newer
	assign lb_wr = '{older: lb_rd.newer, newer: px_s1};

	lbp_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_c),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	// Window kept as its two right columns; index 0 top, 2 bottom.
	// After a shift the left column is the old middle one.
	lbp_pkg::pixel_t win_mid_q [3];
	lbp_pkg::pixel_t win_right_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_mid_q[i]   <= '0;
				win_right_q[i] <= '0;
			end
		end else if (s1_adv) begin
			for (int i = 0; i < 3; i++) begin
				win_mid_q[i] <= win_right_q[i];
			end
			win_right_q[0] <= lb_rd.older;
			win_right_q[1] <= lb_rd.newer;
			win_right_q[2] <= px_s1;
		end
	end

	// Pattern on the shifted window: centre is the old right-middle pixel
	logic [lbp_pkg::PIX_W-1:0] code_c;
	lbp_pkg::pixel_t           ctr;

	assign ctr = win_right_q[1];

	always_comb begin
		code_c[0] = win_mid_q[0]   > ctr;  // top-left
		code_c[1] = win_right_q[0] > ctr;  // top
		code_c[2] = lb_rd.older    > ctr;  // top-right
		code_c[3] = lb_rd.newer    > ctr;  // right
		code_c[4] = px_s1          > ctr;  // bottom-right
		code_c[5] = win_right_q[2] > ctr;  // bottom
		code_c[6] = win_mid_q[2]   > ctr;  // bottom-left
		code_c[7] = win_mid_q[1]   > ctr;  // left
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	lbp_pkg::code_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (code.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_q <= '{lbp_code: code_c, row_last: row_last_s1, frame_last: frame_last_s1};
		end
	end

	assign code.valid = out_valid_q;
	assign code.data  = out_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`LBP_ASSERT_SAME(a_no_overwrite, out_valid_q && !code.ready, !(s1_adv && emit_s1), "code word overwritten while stalled")
	`LBP_ASSERT_SAME(a_frame_last_row_last, out_valid_q && out_q.frame_last, out_q.row_last, "frame_last without row_last")
	`LBP_ASSERT_NEXT(a_col_in_range, accept, WID_W'(col_q) < $past(w_eff), "column position past width")

endmodule
